FILE: rtl/core/sorted_key_table_macros.svh
// Assertion macros shared by the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!(rstn_s)) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/skt_pkg.sv
// Types and codes shared by the sorted key table modules.
package skt_pkg;

    localparam int KEY_W = 16;
    localparam int PAY_W = 32;
    localparam int CNT_W = 5;

    typedef enum logic [1:0] {
        ACT_INSERT,
        ACT_FIND,
        ACT_REMOVE
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_MISSING,
        ST_FULL
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_PUT
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } entry_t;

endpackage

FILE: rtl/core/skt_entry_ram.sv
// Entry store: one write port, one read port, registered read data.
module skt_entry_ram #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  skt_pkg::entry_t          wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output skt_pkg::entry_t          rd_data
);
    import skt_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/core/sorted_key_table.sv
// Sorted key table top level: ordered insert, find and remove over an entry RAM.
//
//   channel   direction  handshake             fields
//   command   in         start & !busy         action, key, payload
//   result    out        done (one cycle)      status, found_payload, entry_count
//
// One item at a time. Insert walks down from the last entry, shifting
// each larger entry up one slot per cycle; find and remove walk up from entry 0,
// remove shifting later entries down. The walk is bound by the single RAM read
// port, one entry a cycle: the result strobe follows at the edge that ends an
// item, and the next command may start then.
// Reset clears the fill level and control state at once; the RAM is not cleared
// since only entries below the fill level are ever read.
// The result receiver cannot stall; done pulses for exactly one cycle.
`include "sorted_key_table_macros.svh"

module sorted_key_table #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [15:0] key,
    input  logic [31:0] payload,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] found_payload,
    output logic [4:0]  entry_count
);
    import skt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_FILL = CW'(CAPACITY);

    // control and command registers
    state_t             state_reg, state_next;
    logic [1:0]         act_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [PAY_W-1:0]   pay_reg;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic               found_reg, found_next;

    // result registers
    logic               done_reg;
    status_t            status_reg;
    logic [PAY_W-1:0]   found_pay_reg;
    logic [CNT_W-1:0]   count_reg;

    // RAM side
    logic               rd_en, wr_en;
    logic [AW-1:0]      rd_addr, wr_addr;
    entry_t             wr_data, rd_data;

    // finishing strobe and result values for this cycle
    logic               fin;
    status_t            res_status;
    logic [PAY_W-1:0]   res_pay;

    logic               accept;
    logic               fill_zero;
    logic [AW-1:0]      last_idx;
    logic               is_last;
    logic               key_gt;
    logic               key_eq;
    logic [CW+CNT_W-1:0] fill_wide;

    assign accept    = start && (state_reg == S_IDLE);
    assign fill_zero = (fill_reg == '0);
    assign last_idx  = AW'(fill_reg - CW'(1));
    assign is_last   = (idx_reg == last_idx);
    assign key_gt    = (rd_data.key > key_reg);
    assign key_eq    = (rd_data.key == key_reg);
    assign fill_wide = {{CNT_W{1'b0}}, fill_next};

    skt_entry_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_INSERT:
                        begin
                            if (!(fill_reg == CAP_FILL) && !fill_zero)
                            begin
                                state_next = S_WALK;
                            end
                        end
                        ACT_FIND, ACT_REMOVE:
                        begin
                            if (!fill_zero)
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                unique case (act_reg)
                    ACT_INSERT:
                    begin
                        if (!key_gt)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (idx_reg == '0)
                        begin
                            state_next = S_PUT;
                        end
                    end
                    ACT_FIND:
                    begin
                        if (key_eq || is_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (is_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_PUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and RAM controls
    always_comb
    begin
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '{key: key_reg, payload: pay_reg};
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        found_next = found_reg;
        fin        = 1'b0;
        res_status = ST_DONE;
        res_pay    = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_INSERT:
                        begin
                            if (fill_reg == CAP_FILL)
                            begin
                                fin        = 1'b1;
                                res_status = ST_FULL;
                            end
                            else if (fill_zero)
                            begin
                                // empty table: store straight into slot 0
                                wr_en     = 1'b1;
                                wr_data   = '{key: key, payload: payload};
                                fill_next = fill_reg + CW'(1);
                                fin       = 1'b1;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                rd_addr  = last_idx;
                                idx_next = last_idx;
                            end
                        end
                        ACT_FIND, ACT_REMOVE:
                        begin
                            found_next = 1'b0;
                            if (fill_zero)
                            begin
                                fin        = 1'b1;
                                res_status = ST_MISSING;
                            end
                            else
                            begin
                                rd_en    = 1'b1;
                                idx_next = '0;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                unique case (act_reg)
                    ACT_INSERT:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(idx_reg + AW'(1));
                        if (key_gt)
                        begin
                            // larger entry moves up one slot
                            wr_data = rd_data;
                            if (idx_reg != '0)
                            begin
                                rd_en    = 1'b1;
                                rd_addr  = AW'(idx_reg - AW'(1));
                                idx_next = AW'(idx_reg - AW'(1));
                            end
                        end
                        else
                        begin
                            fill_next = fill_reg + CW'(1);
                            fin       = 1'b1;
                        end
                    end
                    ACT_FIND:
                    begin
                        if (key_eq)
                        begin
                            fin     = 1'b1;
                            res_pay = rd_data.payload;
                        end
                        else if (is_last)
                        begin
                            fin        = 1'b1;
                            res_status = ST_MISSING;
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = AW'(idx_reg + AW'(1));
                            idx_next = AW'(idx_reg + AW'(1));
                        end
                    end
                    default:
                    begin
                        // remove: after the first match, close the gap behind it
                        if (found_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(idx_reg - AW'(1));
                            wr_data = rd_data;
                        end
                        else if (key_eq)
                        begin
                            found_next = 1'b1;
                        end
                        if (is_last)
                        begin
                            fin = 1'b1;
                            if (found_reg || key_eq)
                            begin
                                fill_next = fill_reg - CW'(1);
                            end
                            else
                            begin
                                res_status = ST_MISSING;
                            end
                        end
                        else
                        begin
                            rd_en    = 1'b1;
                            rd_addr  = AW'(idx_reg + AW'(1));
                            idx_next = AW'(idx_reg + AW'(1));
                        end
                    end
                endcase
            end
            S_PUT:
            begin
                // all entries were larger: new one lands in slot 0
                wr_en     = 1'b1;
                fill_next = fill_reg + CW'(1);
                fin       = 1'b1;
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            found_reg <= found_next;
            done_reg  <= fin;
        end
    end

    // command capture and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (accept)
        begin
            act_reg <= action;
            key_reg <= key;
            pay_reg <= payload;
        end
        if (fin)
        begin
            status_reg    <= res_status;
            found_pay_reg <= res_pay;
            count_reg     <= fill_wide[CNT_W-1:0];
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign found_payload = found_pay_reg;
    assign entry_count   = count_reg;

    // checks on the table's own bookkeeping
    `SKT_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CAP_FILL, "fill above capacity")
    `SKT_ASSERT_NOW(a_wr_when_active, clk, rst_n, wr_en, accept || (state_reg != S_IDLE), "RAM write while idle")
    `SKT_ASSERT_NOW(a_miss_zero_payload, clk, rst_n, done && (status != ST_DONE), found_payload == '0, "nonzero payload on failure")
    `SKT_ASSERT_NEXT(a_full_keeps_fill, clk, rst_n, accept && (action == ACT_INSERT) && (fill_reg == CAP_FILL), done && (fill_reg == CAP_FILL), "full insert changed table")

endmodule
